>>> rtl/i2c_master_bit_engine_defines.svh
// Assertion macros for the I2C master bit engine.
// Taken in by the top level; no other dependencies.
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IBE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c bit engine: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define IBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c bit engine: next-cycle check failed");

`endif

>>> rtl/ibe_pkg.sv
// Shared types and constants for the I2C master bit engine.
// No dependencies.
`default_nettype none

package ibe_pkg;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  localparam logic [2:0]  KIND_MAX          = 3'd4;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
  localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

  // One classified tick as it travels through the queue.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data_byte;
    logic       ack_bit;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_seen;
    logic       rejected;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/i2c_master_bit_engine.sv
// I2C master bit engine: one result per tick, open-drain SCL/SDA levels.
// An input transfer is written into the queue, then a sequencer step registers the result.
// Throughput one tick per cycle while results are taken; a stalled output holds the sequencer.
// Asynchronous active-low reset: line state released (the result register is not reset),
// sequencer idle, queue empty, half period back to five ticks.
`default_nettype none
`include "i2c_master_bit_engine_defines.svh"

module i2c_master_bit_engine #(
  parameter int DELAY_WIDTH = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        ack_bit_i,
  input  wire logic        sda_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             scl_out_o,
  output logic             sda_out_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic [7:0]       read_data_o,
  output logic             nack_seen_o,
  output logic             rejected_o
);
  import ibe_pkg::*;

  logic [15:0]  half_period_q;
  fifo_status_t fifo_st;
  item_t        front_item;
  item_t        queue_item;
  logic         fifo_push;
  logic         fifo_pop;
  result_t      res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RESET;
    end else if (cfg_we_i) begin
      half_period_q <= cfg_wdata_i;
    end
  end

  ibe_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .ack_bit_i   (ack_bit_i),
    .sda_in_i    (sda_in_i),
    .fifo_st_i   (fifo_st),
    .push_o      (fifo_push),
    .item_o      (front_item)
  );

  ibe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .item_i (front_item),
    .pop_i  (fifo_pop),
    .item_o (queue_item),
    .st_o   (fifo_st)
  );

  ibe_back #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .half_period_i (half_period_q),
    .item_i        (queue_item),
    .item_valid_i  (!fifo_st.empty),
    .pop_o         (fifo_pop),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .res_o         (res)
  );

  assign scl_out_o   = res.scl_out;
  assign sda_out_o   = res.sda_out;
  assign busy_res_o  = res.busy_res;
  assign done_res_o  = res.done_res;
  assign read_data_o = res.read_data;
  assign nack_seen_o = res.nack_seen;
  assign rejected_o  = res.rejected;

  `IBE_ASSERT_IMPL(a_done_not_busy, clk_i, rst_ni, out_valid_o && done_res_o, !busy_res_o)
  `IBE_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, fifo_push && fifo_st.full, fifo_pop)
  `IBE_ASSERT_IMPL(a_no_pop_stalled, clk_i, rst_ni, out_valid_o && !out_ready_i, !fifo_pop)
  `IBE_ASSERT_NEXT(a_pop_gives_result, clk_i, rst_ni, fifo_pop, out_valid_o)

endmodule

`default_nettype wire

>>> rtl/ibe_front.sv
// Front end: accepts ticks and classifies the command kind.
// Depends on ibe_pkg.
`default_nettype none

module ibe_front (
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [2:0]           kind_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 ack_bit_i,
  input  wire logic                 sda_in_i,
  input  wire ibe_pkg::fifo_status_t fifo_st_i,
  output logic                      push_o,
  output ibe_pkg::item_t            item_o
);
  import ibe_pkg::*;

  assign in_ready_o = !fifo_st_i.full;
  assign push_o     = in_valid_i && !fifo_st_i.full;

  // Unused kind codes travel as plain ticks.
  always_comb begin
    item_o.cmd       = (kind_i <= KIND_MAX) ? cmd_e'(kind_i) : CMD_NONE;
    item_o.data_byte = data_byte_i;
    item_o.ack_bit   = ack_bit_i;
    item_o.sda_in    = sda_in_i;
  end

endmodule

`default_nettype wire

>>> rtl/ibe_fifo.sv
// Short queue between the front end and the bus sequencer.
// Depends on ibe_pkg.
`default_nettype none

module ibe_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ibe_pkg::item_t item_i,
  input  wire logic           pop_i,
  output ibe_pkg::item_t      item_o,
  output ibe_pkg::fifo_status_t st_o
);
  import ibe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign st_o.full  = (count_q == CNT_W'(DEPTH));
  assign st_o.empty = (count_q == '0);
  assign item_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ibe_back.sv
// Back end: bus phase sequencer, one queued tick per step, with output register.
// Depends on ibe_pkg.
`default_nettype none

module ibe_back #(
  parameter int DELAY_WIDTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [15:0]   half_period_i,
  input  wire ibe_pkg::item_t item_i,
  input  wire logic          item_valid_i,
  output logic               pop_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output ibe_pkg::result_t   res_o
);
  import ibe_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B,
    PH_BIT_HIGH, PH_BIT_LOW, PH_ACK_HIGH, PH_ACK_LOW
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [3:0]             bit_idx_q, bit_idx_d;
  logic [7:0]             shift_q, shift_d;
  logic [DELAY_WIDTH-1:0] delay_q, delay_d;
  cmd_e                   act_q, act_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic                   nack_q, nack_d;
  logic                   ack_send_q, ack_send_d;
  logic [7:0]             rd_hold_q, rd_hold_d;
  logic                   out_valid_q;
  result_t                res_q, res_d;

  logic [DELAY_WIDTH+15:0] hp_ext;
  logic [DELAY_WIDTH-1:0]  dly_load;
  logic [DELAY_WIDTH-1:0]  dly_dec;
  logic [3:0]              bit_inc;
  logic                    is_cmd;
  logic                    done;
  logic                    rej;

  // Mask the half period to the counter width; zero counts as one tick.
  assign hp_ext   = {{DELAY_WIDTH{1'b0}}, half_period_i};
  assign dly_load = (hp_ext[DELAY_WIDTH-1:0] == '0) ? DELAY_WIDTH'(1)
                                                    : hp_ext[DELAY_WIDTH-1:0];
  assign dly_dec  = (delay_q != '0) ? delay_q - 1'b1 : delay_q;
  assign bit_inc  = bit_idx_q + 1'b1;
  assign is_cmd   = (item_i.cmd != CMD_NONE);

  assign pop_o       = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    phase_d    = phase_q;
    bit_idx_d  = bit_idx_q;
    shift_d    = shift_q;
    delay_d    = delay_q;
    act_d      = act_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    nack_d     = nack_q;
    ack_send_d = ack_send_q;
    rd_hold_d  = rd_hold_q;
    done       = 1'b0;
    rej        = 1'b0;

    if (phase_q != PH_IDLE) begin
      rej     = is_cmd;
      delay_d = dly_dec;
      if (dly_dec == '0) begin
        unique case (phase_q)
          PH_START_A: begin
            phase_d = PH_START_B;
            scl_d   = 1'b1;
            sda_d   = 1'b0;
            delay_d = dly_load;
          end
          PH_START_B: begin
            scl_d = 1'b0;
            done  = 1'b1;
          end
          PH_STOP_A: begin
            phase_d = PH_STOP_B;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
            delay_d = dly_load;
          end
          PH_STOP_B: begin
            done = 1'b1;
          end
          PH_BIT_HIGH: begin
            if (act_q == CMD_READ) begin
              shift_d = {shift_q[6:0], item_i.sda_in};
            end
            phase_d = PH_BIT_LOW;
            scl_d   = 1'b0;
            delay_d = dly_load;
          end
          PH_BIT_LOW: begin
            if (act_q == CMD_WRITE) begin
              shift_d = {shift_q[6:0], 1'b0};
            end
            bit_idx_d = bit_inc;
            scl_d     = 1'b1;
            delay_d   = dly_load;
            if (bit_inc < BITS_PER_BYTE) begin
              phase_d = PH_BIT_HIGH;
              sda_d   = (act_q == CMD_WRITE) ? shift_q[6] : 1'b1;
            end else begin
              phase_d = PH_ACK_HIGH;
              sda_d   = (act_q == CMD_WRITE) ? 1'b1 : ack_send_q;
            end
          end
          PH_ACK_HIGH: begin
            if (act_q == CMD_WRITE) begin
              nack_d = item_i.sda_in;
            end
            phase_d = PH_ACK_LOW;
            scl_d   = 1'b0;
            delay_d = dly_load;
          end
          PH_ACK_LOW: begin
            if (act_q == CMD_READ) begin
              rd_hold_d = shift_q;
            end
            done = 1'b1;
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          phase_d = PH_IDLE;
          delay_d = '0;
        end
      end
    end else if (is_cmd) begin
      act_d     = item_i.cmd;
      bit_idx_d = '0;
      scl_d     = 1'b1;
      delay_d   = dly_load;
      unique case (item_i.cmd)
        CMD_START: begin
          phase_d = PH_START_A;
          sda_d   = 1'b1;
        end
        CMD_STOP: begin
          phase_d = PH_STOP_A;
          sda_d   = 1'b0;
        end
        CMD_WRITE: begin
          phase_d = PH_BIT_HIGH;
          shift_d = item_i.data_byte;
          sda_d   = item_i.data_byte[7];
        end
        default: begin
          phase_d    = PH_BIT_HIGH;
          shift_d    = '0;
          ack_send_d = item_i.ack_bit;
          sda_d      = 1'b1;
        end
      endcase
    end

    res_d.scl_out   = scl_d;
    res_d.sda_out   = sda_d;
    res_d.busy_res  = (phase_d != PH_IDLE);
    res_d.done_res  = done;
    res_d.read_data = rd_hold_d;
    res_d.nack_seen = nack_d;
    res_d.rejected  = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_idx_q   <= '0;
      shift_q     <= '0;
      delay_q     <= '0;
      act_q       <= CMD_NONE;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      nack_q      <= 1'b0;
      ack_send_q  <= 1'b0;
      rd_hold_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q    <= phase_d;
        bit_idx_q  <= bit_idx_d;
        shift_q    <= shift_d;
        delay_q    <= delay_d;
        act_q      <= act_d;
        scl_q      <= scl_d;
        sda_q      <= sda_d;
        nack_q     <= nack_d;
        ack_send_q <= ack_send_d;
        rd_hold_q  <= rd_hold_d;
      end
      // Hold the result until taken; refill on the same edge it leaves.
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire
